/* rtl/core/owtp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owtp_pkg: shared types and constants of the thermometer poller
// Command codes, sequencer phases, one-wire command bytes and the transfer
// request bundle passed from the sequencer to the top level.
// ----------------------------------------------------------------------------
package owtp_pkg;

	localparam logic [1:0] CMD_TICK    = 2'd0;
	localparam logic [1:0] CMD_REQUEST = 2'd1;
	localparam logic [1:0] CMD_DONE    = 2'd2;
	localparam logic [1:0] CMD_POLL    = 2'd3;

	localparam logic [2:0] PH_IDLE        = 3'd0;
	localparam logic [2:0] PH_GET_SERIAL  = 3'd1;
	localparam logic [2:0] PH_SERIAL_WAIT = 3'd2;
	localparam logic [2:0] PH_CONVERT     = 3'd3;
	localparam logic [2:0] PH_READ_PAD    = 3'd4;
	localparam logic [2:0] PH_TEMP_WAIT   = 3'd5;

	localparam logic [1:0] KIND_NINE    = 2'd0;
	localparam logic [1:0] KIND_TWELVE  = 2'd1;
	localparam logic [1:0] KIND_UNKNOWN = 2'd2;

	localparam logic [7:0] FAMILY_TWELVE = 8'h28;
	localparam logic [7:0] FAMILY_NINE   = 8'h10;

	localparam logic [15:0] TX_READ_ROM  = 16'h0033;
	localparam logic [15:0] TX_CONVERT   = 16'h44CC;
	localparam logic [15:0] TX_READ_PAD  = 16'hBECC;

	localparam logic [3:0] RX_ROM_BYTES = 4'd8;
	localparam logic [3:0] RX_PAD_BYTES = 4'd9;

	localparam logic [15:0] REFRESH_RESET = 16'd1000;
	localparam logic [15:0] CONVWAIT_RESET = 16'd800;

	localparam logic REG_REFRESH  = 1'b0;
	localparam logic REG_CONVWAIT = 1'b1;

	typedef struct packed {
		logic        start;
		logic [15:0] tx_bytes;
		logic [1:0]  tx_count;
		logic [3:0]  rx_count;
		logic        check_crc;
	} xfer_t;

endpackage

/* rtl/core/owtp_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owtp_seq: poll sequencer
// Holds phase, tick counter, sensor kind, ROM code, fail flag and the last
// temperature; computes the updated state and transfer request for one item.
// ----------------------------------------------------------------------------
module owtp_seq #(
	parameter int TICK_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic [1:0]           cmd,
	input  logic                 wire_busy,
	input  logic                 wire_error,
	input  logic [63:0]          rx_data,
	input  logic [15:0]          refresh_period,
	input  logic [15:0]          conversion_wait,
	output owtp_pkg::xfer_t      xfer,
	output logic                 fail_nx,
	output logic [1:0]           kind_nx,
	output logic [63:0]          rom_nx,
	output logic [7:0]           temp_nx
);
	import owtp_pkg::*;

	localparam int CMP_W = (TICK_BITS > 16) ? TICK_BITS : 16;
	localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

	logic [2:0]           phase_q, phase_nx;
	logic [TICK_BITS-1:0] tick_q, tick_inc, tick_nx;
	logic [1:0]           kind_q;
	logic                 fail_q;
	logic [63:0]          rom_q;
	logic [7:0]           temp_q;
	logic [CMP_W-1:0]     tick_w, refresh_w, wait_w;

	assign tick_inc  = (cmd == CMD_TICK && tick_q != TICK_MAX) ? tick_q + 1'b1 : tick_q;
	assign tick_w    = CMP_W'(tick_inc);
	assign refresh_w = CMP_W'(refresh_period);
	assign wait_w    = CMP_W'(conversion_wait);

	always_comb begin
		phase_nx = phase_q;
		tick_nx  = tick_inc;
		kind_nx  = kind_q;
		fail_nx  = fail_q;
		rom_nx   = rom_q;
		temp_nx  = temp_q;
		xfer     = '0;
		case (phase_q)
			PH_IDLE: begin
				if (cmd == CMD_REQUEST) begin
					phase_nx = PH_GET_SERIAL;
				end else if (kind_q != KIND_UNKNOWN && tick_w > refresh_w) begin
					phase_nx = PH_CONVERT;
				end
			end
			PH_GET_SERIAL: begin
				if (!wire_busy) begin
					xfer     = '{1'b1, TX_READ_ROM, 2'd1, RX_ROM_BYTES, 1'b1};
					fail_nx  = 1'b0;
					phase_nx = PH_SERIAL_WAIT;
				end
			end
			PH_SERIAL_WAIT: begin
				if (cmd == CMD_DONE) begin
					if (!wire_error) begin
						rom_nx = rx_data;
						if (rx_data[7:0] == FAMILY_TWELVE) begin
							kind_nx = KIND_TWELVE;
						end else if (rx_data[7:0] == FAMILY_NINE) begin
							kind_nx = KIND_NINE;
						end else begin
							kind_nx = KIND_UNKNOWN;
						end
					end else begin
						fail_nx = 1'b1;
					end
					phase_nx = PH_IDLE;
					tick_nx  = '0;
				end
			end
			PH_CONVERT: begin
				if (!wire_busy) begin
					xfer     = '{1'b1, TX_CONVERT, 2'd2, 4'd0, 1'b0};
					fail_nx  = 1'b0;
					phase_nx = PH_READ_PAD;
					tick_nx  = '0;
				end
			end
			PH_READ_PAD: begin
				if (tick_w > wait_w) begin
					if (wire_error) begin
						fail_nx  = 1'b1;
						phase_nx = PH_IDLE;
					end else if (!wire_busy) begin
						xfer     = '{1'b1, TX_READ_PAD, 2'd2, RX_PAD_BYTES, 1'b1};
						phase_nx = PH_TEMP_WAIT;
					end
				end
			end
			PH_TEMP_WAIT: begin
				if (cmd == CMD_DONE) begin
					if (!wire_error) begin
						// whole degrees: 1/16 steps for twelve-bit, 1/2 otherwise
						temp_nx = (kind_q == KIND_TWELVE) ? rx_data[11:4] : rx_data[8:1];
					end else begin
						fail_nx = 1'b1;
					end
					phase_nx = PH_IDLE;
				end
			end
			default: begin
				phase_nx = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			kind_q  <= KIND_NINE;
			fail_q  <= 1'b0;
			rom_q   <= '0;
			temp_q  <= '0;
		end else if (advance) begin
			phase_q <= phase_nx;
			tick_q  <= tick_nx;
			kind_q  <= kind_nx;
			fail_q  <= fail_nx;
			rom_q   <= rom_nx;
			temp_q  <= temp_nx;
		end
	end

endmodule

/* rtl/core/owtp_fmt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owtp_fmt: temperature formatter
// Splits a signed whole-degree value into sign, magnitude and three packed
// BCD digits.
// ----------------------------------------------------------------------------
module owtp_fmt (
	input  logic [7:0]  temp,
	output logic        negative,
	output logic [7:0]  magnitude,
	output logic [11:0] bcd
);
	logic [7:0]  rem;
	logic [14:0] prod;
	logic [3:0]  tens;
	logic [6:0]  tens_x10;
	logic [3:0]  ones;
	logic        hundreds;

	assign negative  = temp[7];
	assign magnitude = negative ? 8'(~temp + 8'd1) : temp;
	assign hundreds  = (magnitude >= 8'd100);
	assign rem       = hundreds ? magnitude - 8'd100 : magnitude;
	// rem < 100: rem/10 == (rem*205) >> 11
	assign prod      = 15'(rem[6:0]) * 15'd205;
	assign tens      = prod[14:11];
	assign tens_x10  = 7'(tens) * 7'd10;
	assign ones      = 4'(rem[6:0] - tens_x10);
	assign bcd       = {3'b000, hundreds, tens, ones};

endmodule

/* rtl/core/onewire_temp_sensor_poller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onewire_temp_sensor_poller: one-wire thermometer polling controller
// Drives a one-wire master through ROM read, convert and scratchpad read and
// reports the sensor kind, ROM code and temperature in several formats.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready) carries one event per transaction:
//    tick, read-serial request, transfer complete or poll, with the master's
//    busy/error status and the received bytes.
//  - Output channel (out_valid/out_ready) returns exactly one result per
//    input transaction: an optional transfer request for the master plus the
//    fail flag, sensor kind, ROM code and the last temperature.
//  - An accepted input passes the input register, then the sequencer into
//    the result register, before out_valid rises.
//  - Throughput is one transaction per cycle while out_ready stays high; the
//    sequencer state update is a single short pass, so back-to-back events carry through.
//  - When the receiver stalls, the result register holds and the input
//    register fills; in_ready drops only once both are occupied.
//  - Reset puts the sequencer in idle with a nine-bit sensor assumed, all
//    counters and stored values zero, refresh_period 1000, conversion_wait
//    800 ticks.
//  - APB registers: 0x0 refresh_period, 0x4 conversion_wait (write when idle).
// ----------------------------------------------------------------------------
module onewire_temp_sensor_poller #(
	parameter int TICK_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// APB configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// input channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic               wire_busy,
	input  logic               wire_error,
	input  logic [63:0]        rx_data,
	// output channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic               start_transfer,
	output logic [15:0]        tx_bytes,
	output logic [1:0]         tx_count,
	output logic [3:0]         rx_count,
	output logic               check_crc,
	output logic               failed,
	output logic [1:0]         sensor_kind,
	output logic [63:0]        rom_code,
	output logic signed [7:0]  temp_degrees,
	output logic               temp_negative,
	output logic [7:0]         temp_magnitude,
	output logic [11:0]        temp_bcd
);
	import owtp_pkg::*;

	logic [15:0] refresh_q, convwait_q;
	logic        cfg_wr;

	logic        valid_s1;
	logic [1:0]  cmd_s1;
	logic        busy_s1;
	logic        err_s1;
	logic [63:0] rx_s1;

	logic        load_out;
	logic        advance;

	xfer_t       xfer;
	logic        fail_nx;
	logic [1:0]  kind_nx;
	logic [63:0] rom_nx;
	logic [7:0]  temp_nx;
	logic        neg_nx;
	logic [7:0]  mag_nx;
	logic [11:0] bcd_nx;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_CONVWAIT) ? {16'd0, convwait_q} : {16'd0, refresh_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refresh_q  <= REFRESH_RESET;
			convwait_q <= CONVWAIT_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_CONVWAIT) begin
				convwait_q <= pwdata[15:0];
			end else begin
				refresh_q <= pwdata[15:0];
			end
		end
	end

	// result register frees up when empty or being taken
	assign load_out = !out_valid || out_ready;
	assign advance  = valid_s1 && load_out;
	assign in_ready = !valid_s1 || load_out;

	// input register: hold while the result side is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1  <= cmd;
			busy_s1 <= wire_busy;
			err_s1  <= wire_error;
			rx_s1   <= rx_data;
		end
	end

	owtp_seq #(
		.TICK_BITS(TICK_BITS)
	) u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.advance         (advance),
		.cmd             (cmd_s1),
		.wire_busy       (busy_s1),
		.wire_error      (err_s1),
		.rx_data         (rx_s1),
		.refresh_period  (refresh_q),
		.conversion_wait (convwait_q),
		.xfer            (xfer),
		.fail_nx         (fail_nx),
		.kind_nx         (kind_nx),
		.rom_nx          (rom_nx),
		.temp_nx         (temp_nx)
	);

	owtp_fmt u_fmt (
		.temp      (temp_nx),
		.negative  (neg_nx),
		.magnitude (mag_nx),
		.bcd       (bcd_nx)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			start_transfer <= xfer.start;
			tx_bytes       <= xfer.tx_bytes;
			tx_count       <= xfer.tx_count;
			rx_count       <= xfer.rx_count;
			check_crc      <= xfer.check_crc;
			failed         <= fail_nx;
			sensor_kind    <= kind_nx;
			rom_code       <= rom_nx;
			temp_degrees   <= signed'(temp_nx);
			temp_negative  <= neg_nx;
			temp_magnitude <= mag_nx;
			temp_bcd       <= bcd_nx;
		end
	end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the one-wire thermometer poller
// Feeds tick, request, completion and poll events through the input channel,
// keeps its own copy of the sequencer to predict every result, and compares
// each result transaction field by field. Covers ROM reads, conversions,
// scratchpad reads, master errors and busy stalls, output back-pressure and
// the longest refresh and conversion settings.
// ----------------------------------------------------------------------------
module tb_top;
	import owtp_pkg::*;

	typedef struct packed {
		logic        start;
		logic [15:0] tx_bytes;
		logic [1:0]  tx_count;
		logic [3:0]  rx_count;
		logic        check_crc;
		logic        failed;
		logic [1:0]  kind;
		logic [63:0] rom;
		logic [7:0]  degrees;
		logic        negative;
		logic [7:0]  magnitude;
		logic [11:0] bcd;
	} poll_result_t;

	// Clock, reset and every block input start at known values
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  cmd = CMD_TICK;
	logic        wire_busy = 1'b0;
	logic        wire_error = 1'b0;
	logic [63:0] rx_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        start_transfer;
	logic [15:0] tx_bytes;
	logic [1:0]  tx_count;
	logic [3:0]  rx_count;
	logic        check_crc;
	logic        failed;
	logic [1:0]  sensor_kind;
	logic [63:0] rom_code;
	logic signed [7:0] temp_degrees;
	logic        temp_negative;
	logic [7:0]  temp_magnitude;
	logic [11:0] temp_bcd;

	// Own copy of the sequencer state and its two registers
	logic [2:0]  m_phase = PH_IDLE;
	logic [1:0]  m_kind = KIND_NINE;
	logic [15:0] m_ticks = '0;
	logic        m_fail = 1'b0;
	logic [63:0] m_rom = '0;
	logic [7:0]  m_temp = '0;
	logic [15:0] m_refresh = REFRESH_RESET;
	logic [15:0] m_convwait = CONVWAIT_RESET;

	poll_result_t pending_results[$];

	logic valid_driven = 1'b0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_requests = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_rom_reads = 0;
	int n_readings = 0;

	onewire_temp_sensor_poller dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.cmd            (cmd),
		.wire_busy      (wire_busy),
		.wire_error     (wire_error),
		.rx_data        (rx_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.start_transfer (start_transfer),
		.tx_bytes       (tx_bytes),
		.tx_count       (tx_count),
		.rx_count       (rx_count),
		.check_crc      (check_crc),
		.failed         (failed),
		.sensor_kind    (sensor_kind),
		.rom_code       (rom_code),
		.temp_degrees   (temp_degrees),
		.temp_negative  (temp_negative),
		.temp_magnitude (temp_magnitude),
		.temp_bcd       (temp_bcd)
	);

	always #5 clk = ~clk;

	// Advance the local sequencer by one event and return the result it owes.
	// Ticks count first, then the current phase is evaluated once.
	function automatic poll_result_t advance_sequencer(input logic [1:0] c, input logic b,
			input logic e, input logic [63:0] d);
		poll_result_t r;
		logic signed [15:0] raw;
		logic [7:0] mag;
		r = '0;
		if (c == CMD_TICK && m_ticks != 16'hFFFF)
			m_ticks++;
		case (m_phase)
			PH_IDLE: begin
				// a request always wins over a due conversion
				if (c == CMD_REQUEST)
					m_phase = PH_GET_SERIAL;
				else if (m_kind != KIND_UNKNOWN && m_ticks > m_refresh)
					m_phase = PH_CONVERT;
			end
			PH_GET_SERIAL: begin
				if (!b) begin
					r.start = 1'b1;
					r.tx_bytes = TX_READ_ROM;
					r.tx_count = 2'd1;
					r.rx_count = RX_ROM_BYTES;
					r.check_crc = 1'b1;
					m_fail = 1'b0;
					m_phase = PH_SERIAL_WAIT;
				end
			end
			PH_SERIAL_WAIT: begin
				if (c == CMD_DONE) begin
					if (!e) begin
						m_rom = d;
						if (d[7:0] == FAMILY_TWELVE)
							m_kind = KIND_TWELVE;
						else if (d[7:0] == FAMILY_NINE)
							m_kind = KIND_NINE;
						else
							m_kind = KIND_UNKNOWN;
						n_rom_reads++;
					end else begin
						m_fail = 1'b1;
					end
					m_phase = PH_IDLE;
					m_ticks = '0;
				end
			end
			PH_CONVERT: begin
				if (!b) begin
					r.start = 1'b1;
					r.tx_bytes = TX_CONVERT;
					r.tx_count = 2'd2;
					m_fail = 1'b0;
					m_phase = PH_READ_PAD;
					m_ticks = '0;
				end
			end
			PH_READ_PAD: begin
				if (m_ticks > m_convwait) begin
					if (e) begin
						m_fail = 1'b1;
						m_phase = PH_IDLE;
					end else if (!b) begin
						r.start = 1'b1;
						r.tx_bytes = TX_READ_PAD;
						r.tx_count = 2'd2;
						r.rx_count = RX_PAD_BYTES;
						r.check_crc = 1'b1;
						m_phase = PH_TEMP_WAIT;
					end
				end
			end
			PH_TEMP_WAIT: begin
				if (c == CMD_DONE) begin
					if (!e) begin
						// twelve-bit readings carry four fraction bits, all others one
						raw = d[15:0];
						m_temp = (m_kind == KIND_TWELVE) ? 8'(raw >>> 4) : 8'(raw >>> 1);
						n_readings++;
					end else begin
						m_fail = 1'b1;
					end
					m_phase = PH_IDLE;
				end
			end
			default: m_phase = PH_IDLE;
		endcase
		mag = m_temp[7] ? 8'(-m_temp) : m_temp;
		r.failed = m_fail;
		r.kind = m_kind;
		r.rom = m_rom;
		r.degrees = m_temp;
		r.negative = m_temp[7];
		r.magnitude = mag;
		r.bcd = {4'(mag / 100), 4'((mag / 10) % 10), 4'(mag % 10)};
		return r;
	endfunction

	// Drop valid once; the mirror keeps a second assignment out of the same step
	task automatic idle_input();
		if (valid_driven) begin
			in_valid <= 1'b0;
			valid_driven = 1'b0;
		end
	endtask

	// Offer one event and hold it until the transaction completes. Start and
	// end just after a falling edge; valid stays up so a following event
	// needs no gap.
	task automatic send_event(input logic [1:0] c, input logic b, input logic e,
			input logic [63:0] d);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			idle_input();
			@(negedge clk);
		end
		pending_results.push_back(advance_sequencer(c, b, e, d));
		in_valid <= 1'b1;
		valid_driven = 1'b1;
		cmd <= c;
		wire_busy <= b;
		wire_error <= e;
		rx_data <= d;
		n_sent++;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Hold off the sender until every outstanding result has come back, then
	// let the two pipeline stages settle
	task automatic await_quiet();
		idle_input();
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// APB write: setup cycle, access cycle, then release the bus
	task automatic write_register(input logic idx, input logic [15:0] value);
		idle_input();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'($urandom), value};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		if (idx == REG_REFRESH)
			m_refresh = value;
		else
			m_convwait = value;
	endtask

	// Mostly short periods so conversions come often, now and then a longer one
	function automatic logic [15:0] pick_setting();
		if ($urandom_range(9) == 0)
			return 16'($urandom_range(7, 40));
		return 16'($urandom_range(0, 6));
	endfunction

	// Pick an event that fits the phase the sequencer is in, so that most
	// traffic walks through whole read sequences; one in ten is plain noise.
	task automatic random_event();
		logic [1:0] c;
		logic b;
		logic e;
		logic [63:0] d;
		d = {$urandom, $urandom};
		b = ($urandom_range(99) < 25);
		e = ($urandom_range(99) < 8);
		if ($urandom_range(99) < 10) begin
			c = 2'($urandom_range(3));
		end else begin
			case (m_phase)
				PH_IDLE: begin
					if ($urandom_range(99) < 12)
						c = CMD_REQUEST;
					else
						c = ($urandom_range(99) < 80) ? CMD_TICK : CMD_POLL;
				end
				PH_SERIAL_WAIT: begin
					c = ($urandom_range(99) < 60) ? CMD_DONE : CMD_TICK;
					case ($urandom_range(2))
						0: d[7:0] = FAMILY_TWELVE;
						1: d[7:0] = FAMILY_NINE;
						default: ;
					endcase
				end
				PH_READ_PAD: c = ($urandom_range(99) < 85) ? CMD_TICK : CMD_POLL;
				PH_TEMP_WAIT: begin
					c = ($urandom_range(99) < 60) ? CMD_DONE : CMD_TICK;
					case ($urandom_range(11))
						0: d[15:0] = 16'h8000;
						1: d[15:0] = 16'h7FFF;
						2: d[15:0] = 16'hFFFF;
						3: d[15:0] = 16'h0000;
						default: ;
					endcase
				end
				default: c = $urandom_range(1) ? CMD_POLL : CMD_TICK;
			endcase
		end
		send_event(c, b, e, d);
	endtask

	// Receiver: stall at random, or hold off for a long stretch on request
	always @(negedge clk) begin
		if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = 150;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endfunction

	// Compare each result transaction against the oldest prediction
	always @(posedge clk) begin
		poll_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with nothing outstanding");
				errors++;
			end else begin
				want = pending_results.pop_front();
				n_checked++;
				check_field("start_transfer", want.start, start_transfer);
				check_field("tx_bytes", want.tx_bytes, tx_bytes);
				check_field("tx_count", want.tx_count, tx_count);
				check_field("rx_count", want.rx_count, rx_count);
				check_field("check_crc", want.check_crc, check_crc);
				check_field("failed", want.failed, failed);
				check_field("sensor_kind", want.kind, sensor_kind);
				check_field("rom_code", want.rom, rom_code);
				check_field("temp_degrees", want.degrees, $unsigned(temp_degrees));
				check_field("temp_negative", want.negative, temp_negative);
				check_field("temp_magnitude", want.magnitude, temp_magnitude);
				check_field("temp_bcd", want.bcd, temp_bcd);
			end
		end
	end

	// Walk the sequencer by hand through every phase, message and error path
	task automatic test_directed_sequences();
		send_idle_pct = 19;
		recv_idle_pct = 73;
		// reset settings: a tick alone does not start a conversion
		send_event(CMD_TICK, 1'b0, 1'b0, '0);
		send_event(CMD_REQUEST, 1'b0, 1'b0, '0);
		// busy master holds the ROM read back
		send_event(CMD_POLL, 1'b1, 1'b0, '0);
		send_event(CMD_POLL, 1'b0, 1'b0, '0);
		// request while waiting for the ROM is dropped
		send_event(CMD_REQUEST, 1'b0, 1'b0, '1);
		// ROM read fails on the wire
		send_event(CMD_DONE, 1'b0, 1'b1, '1);
		// completion in idle is dropped
		send_event(CMD_DONE, 1'b1, 1'b1, '1);
		send_event(CMD_REQUEST, 1'b0, 1'b0, '0);
		send_event(CMD_POLL, 1'b0, 1'b0, '0);
		send_event(CMD_DONE, 1'b0, 1'b0, {56'h0, FAMILY_TWELVE});
		await_quiet();
		write_register(REG_REFRESH, 16'd0);
		write_register(REG_CONVWAIT, 16'd0);
		send_event(CMD_TICK, 1'b0, 1'b0, '0);
		// busy holds the convert; error is not looked at yet
		send_event(CMD_TICK, 1'b1, 1'b1, '0);
		send_event(CMD_POLL, 1'b0, 1'b0, '0);
		send_event(CMD_POLL, 1'b0, 1'b1, '0);
		// wait elapsed with an error pending: fail and back to idle
		send_event(CMD_TICK, 1'b0, 1'b1, '0);
		send_event(CMD_TICK, 1'b0, 1'b0, '0);
		send_event(CMD_POLL, 1'b0, 1'b0, '0);
		send_event(CMD_TICK, 1'b1, 1'b0, '0);
		send_event(CMD_TICK, 1'b0, 1'b0, '0);
		// twelve-bit reading 0x0800 lands on -128: magnitude 128, BCD 128
		send_event(CMD_DONE, 1'b0, 1'b0, 64'h0000_0000_0000_0800);
		// unknown family stops the polling until a new ROM read
		send_event(CMD_REQUEST, 1'b0, 1'b0, '0);
		send_event(CMD_POLL, 1'b0, 1'b0, '0);
		send_event(CMD_DONE, 1'b0, 1'b0, 64'h0000_0000_0000_0055);
		send_event(CMD_TICK, 1'b0, 1'b0, '0);
		// nine-bit family after unknown
		send_event(CMD_REQUEST, 1'b0, 1'b0, '0);
		send_event(CMD_POLL, 1'b0, 1'b0, '0);
		send_event(CMD_DONE, 1'b0, 1'b0, {56'hFF_FFFF_FFFF_FFFF, FAMILY_NINE});
		await_quiet();
	endtask

	// Phase-aware random traffic; re-program both registers now and then
	task automatic test_random_traffic(input int n_items, input int s_pct, input int r_pct);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int i = 0; i < n_items; i++) begin
			if (i % 150 == 0) begin
				await_quiet();
				write_register(REG_REFRESH, pick_setting());
				write_register(REG_CONVWAIT, pick_setting());
			end
			random_event();
		end
		await_quiet();
	endtask

	// Stall the receiver long enough to fill both pipeline stages
	task automatic test_output_stall();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_requests++;
		repeat (20) random_event();
		await_quiet();
	endtask

	// Program the longest refresh and conversion settings: a run of ticks
	// must never start a conversion
	task automatic test_long_periods();
		logic [63:0] d;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		// drive the sequencer back to idle first
		while (m_phase != PH_IDLE) begin
			case (m_phase)
				PH_SERIAL_WAIT, PH_TEMP_WAIT: send_event(CMD_DONE, 1'b0, 1'b0, '0);
				PH_READ_PAD: send_event(CMD_TICK, 1'b0, 1'b1, '0);
				default: send_event(CMD_POLL, 1'b0, 1'b0, '0);
			endcase
		end
		await_quiet();
		write_register(REG_REFRESH, 16'hFFFF);
		write_register(REG_CONVWAIT, 16'hFFFF);
		d = {$urandom, $urandom};
		d[7:0] = FAMILY_TWELVE;
		send_event(CMD_REQUEST, 1'b0, 1'b0, '0);
		send_event(CMD_POLL, 1'b0, 1'b0, '0);
		send_event(CMD_DONE, 1'b0, 1'b0, d);
		repeat (40)
			send_event(CMD_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)),
				{$urandom, $urandom});
		await_quiet();
		write_register(REG_REFRESH, 16'hFFFE);
		send_event(CMD_TICK, 1'b0, 1'b0, '0);
		send_event(CMD_POLL, 1'b0, 1'b0, '0);
		// more ticks with an error pending stay in idle: no conversion starts
		repeat (8) send_event(CMD_TICK, 1'b0, 1'b1, '0);
		await_quiet();
		write_register(REG_CONVWAIT, 16'd0);
		send_event(CMD_POLL, 1'b0, 1'b0, '0);
		d = {$urandom, $urandom};
		send_event(CMD_DONE, 1'b0, 1'b0, d);
		await_quiet();
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_sequences();
		test_random_traffic(540, 19, 73);
		test_random_traffic(540, 73, 19);
		test_random_traffic(540, 0, 0);
		test_output_stall();
		test_long_periods();
		await_quiet();
		repeat (10) @(negedge clk);
		$display("Covered %0d events and %0d results: %0d ROM reads, %0d temperature readings,",
			n_sent, n_checked, n_rom_reads, n_readings);
		$display("both idling mixes, a long output stall and the longest register settings.");
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Bound the run well beyond the slowest legal completion
	initial begin
		#5000000;
		$display("FAIL");
		$finish;
	end

endmodule
